@@ design/blr_pkg.sv @@
// Shared types, constants and helpers of the Bresenham line rasterizer.
`default_nettype none

package blr_pkg;

    // Field widths.
    localparam int COORD_BITS     = 16;
    localparam int DELTA_BITS     = COORD_BITS + 1;
    localparam int ERR_BITS       = COORD_BITS + 3;
    localparam int COLOR_BITS     = 8;
    localparam int DIM_BITS       = 13;
    localparam int MAX_IMAGE_DIM  = 4096;
    localparam int INDEX_BITS     = $clog2(MAX_IMAGE_DIM);
    localparam int PROD_BITS      = INDEX_BITS + DIM_BITS;
    localparam int ADDR_BITS      = 26;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = DIM_BITS;

    // Register reset values.
    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(800);
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(600);

    // Command queue between front and back; depth is a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_NEXT  = 1'b1
    } t_req_type;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_index;

    // Classified command handed from front to back.
    typedef struct packed {
        logic                         is_start;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic [DELTA_BITS-1:0]        delta_x;
        logic [DELTA_BITS-1:0]        delta_y;
        logic                         step_x_neg;
        logic                         step_y_neg;
        logic signed [ERR_BITS-1:0]   error_init;
        logic [3*COLOR_BITS-1:0]      colour;
    } t_cmd;

    // One emitted pixel before clipping and addressing.
    typedef struct packed {
        logic                         valid_res;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         last;
        logic [3*COLOR_BITS-1:0]      colour;
    } t_pix;

    // Image dimension as used for clipping: saturated at the maximum.
    function automatic logic [DIM_BITS-1:0] eff_dim(input logic [DIM_BITS-1:0] r);
        logic [DIM_BITS-1:0] lim;
        lim = DIM_BITS'(MAX_IMAGE_DIM);
        return (r > lim) ? lim : r;
    endfunction

endpackage

`default_nettype wire

@@ design/blr_front.sv @@
// Front end: accepts requests and classifies them into queue commands.
`default_nettype none

module blr_front (
    input  wire logic                                  i_valid,
    input  wire logic                                  i_req_type,
    input  wire logic signed [blr_pkg::COORD_BITS-1:0] i_start_x,
    input  wire logic signed [blr_pkg::COORD_BITS-1:0] i_start_y,
    input  wire logic signed [blr_pkg::COORD_BITS-1:0] i_end_x,
    input  wire logic signed [blr_pkg::COORD_BITS-1:0] i_end_y,
    input  wire logic [blr_pkg::COLOR_BITS-1:0]        i_red,
    input  wire logic [blr_pkg::COLOR_BITS-1:0]        i_green,
    input  wire logic [blr_pkg::COLOR_BITS-1:0]        i_blue,
    input  wire logic                                  i_queue_full,
    output logic                                       o_push,
    output blr_pkg::t_cmd                              o_cmd
);
    import blr_pkg::*;

    logic signed [DELTA_BITS:0] diff_x;
    logic signed [DELTA_BITS:0] diff_y;
    logic [DELTA_BITS-1:0]      abs_x;
    logic [DELTA_BITS-1:0]      abs_y;

    // A transaction is taken whenever the queue has room.
    assign o_push = i_valid && !i_queue_full;

    // Signed endpoint differences and their magnitudes.
    always_comb begin
        diff_x = (DELTA_BITS+1)'(i_end_x) - (DELTA_BITS+1)'(i_start_x);
        diff_y = (DELTA_BITS+1)'(i_end_y) - (DELTA_BITS+1)'(i_start_y);
        abs_x  = diff_x[DELTA_BITS] ? DELTA_BITS'(-diff_x) : DELTA_BITS'(diff_x);
        abs_y  = diff_y[DELTA_BITS] ? DELTA_BITS'(-diff_y) : DELTA_BITS'(diff_y);
    end

    // Build the command. An equal coordinate counts as a negative step.
    always_comb begin
        o_cmd.is_start   = (t_req_type'(i_req_type) == REQ_START);
        o_cmd.start_x    = i_start_x;
        o_cmd.start_y    = i_start_y;
        o_cmd.end_x      = i_end_x;
        o_cmd.end_y      = i_end_y;
        o_cmd.delta_x    = abs_x;
        o_cmd.delta_y    = abs_y;
        o_cmd.step_x_neg = !(i_start_x < i_end_x);
        o_cmd.step_y_neg = !(i_start_y < i_end_y);
        o_cmd.error_init = ERR_BITS'(abs_x) - ERR_BITS'(abs_y);
        o_cmd.colour     = {i_red, i_green, i_blue};
    end

endmodule

`default_nettype wire

@@ design/blr_queue.sv @@
// Short command queue that decouples the front end from the stepper.
`default_nettype none

module blr_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  blr_pkg::t_cmd      i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_valid,
    output blr_pkg::t_cmd      o_cmd
);
    import blr_pkg::*;

    t_cmd                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic [QCNT_BITS-1:0] n_count;

    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Occupancy follows push and pop.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_BITS'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_BITS'(1);
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_BITS'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue occupancy above its depth");

endmodule

`default_nettype wire

@@ design/blr_stepper.sv @@
// Back end stepper: holds the line state and emits one pixel per command.
`default_nettype none

module blr_stepper (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cmd_valid,
    input  blr_pkg::t_cmd i_cmd,
    output logic          o_pop,
    input  wire logic     i_ready,
    output logic          o_valid,
    output blr_pkg::t_pix o_pix
);
    import blr_pkg::*;

    // Line state.
    logic signed [COORD_BITS-1:0] r_cur_x;
    logic signed [COORD_BITS-1:0] r_cur_y;
    logic signed [COORD_BITS-1:0] r_target_x;
    logic signed [COORD_BITS-1:0] r_target_y;
    logic [DELTA_BITS-1:0]        r_delta_x;
    logic [DELTA_BITS-1:0]        r_delta_y;
    logic                         r_step_x_neg;
    logic                         r_step_y_neg;
    logic signed [ERR_BITS-1:0]   r_error_term;
    logic [3*COLOR_BITS-1:0]      r_line_colour;
    logic                         r_line_active;

    // Pixel output register.
    logic r_s1_valid;
    t_pix r_s1_pix;

    // Working values for the current command.
    logic signed [COORD_BITS-1:0] cx, cy, tx, ty;
    logic [DELTA_BITS-1:0]        dx, dy;
    logic                         sxn, syn;
    logic signed [ERR_BITS-1:0]   err;
    logic [3*COLOR_BITS-1:0]      colour;
    logic                         emit;
    logic                         is_last;
    logic signed [ERR_BITS:0]     e2;
    logic                         move_x, move_y;
    logic signed [COORD_BITS-1:0] n_cur_x, n_cur_y;
    logic signed [ERR_BITS-1:0]   n_error_term;
    t_pix                         n_pix;

    assign o_pop   = i_cmd_valid && (!r_s1_valid || i_ready);
    assign o_valid = r_s1_valid;
    assign o_pix   = r_s1_pix;

    // Select fresh endpoints on a start command, else the running state.
    always_comb begin
        if (i_cmd.is_start) begin
            cx     = i_cmd.start_x;
            cy     = i_cmd.start_y;
            tx     = i_cmd.end_x;
            ty     = i_cmd.end_y;
            dx     = i_cmd.delta_x;
            dy     = i_cmd.delta_y;
            sxn    = i_cmd.step_x_neg;
            syn    = i_cmd.step_y_neg;
            err    = i_cmd.error_init;
            colour = i_cmd.colour;
        end else begin
            cx     = r_cur_x;
            cy     = r_cur_y;
            tx     = r_target_x;
            ty     = r_target_y;
            dx     = r_delta_x;
            dy     = r_delta_y;
            sxn    = r_step_x_neg;
            syn    = r_step_y_neg;
            err    = r_error_term;
            colour = r_line_colour;
        end
        emit    = i_cmd.is_start || r_line_active;
        is_last = (cx == tx) && (cy == ty);
    end

    // Bresenham step: compare the doubled error against both deltas as signed values.
    always_comb begin
        e2           = {err, 1'b0};
        move_x       = (e2 > -$signed((ERR_BITS+1)'(dy)));
        move_y       = (e2 < $signed((ERR_BITS+1)'(dx)));
        n_error_term = err;
        n_cur_x      = cx;
        n_cur_y      = cy;
        if (move_x) begin
            n_cur_x = sxn ? cx - COORD_BITS'(1) : cx + COORD_BITS'(1);
        end
        if (move_y) begin
            n_cur_y = syn ? cy - COORD_BITS'(1) : cy + COORD_BITS'(1);
        end
        n_error_term = err - (move_x ? ERR_BITS'(dy) : '0) + (move_y ? ERR_BITS'(dx) : '0);
    end

    // Pixel record; an idle next request gives an all-zero result.
    always_comb begin
        n_pix = '0;
        if (emit) begin
            n_pix.valid_res = 1'b1;
            n_pix.x         = cx;
            n_pix.y         = cy;
            n_pix.last      = is_last;
            n_pix.colour    = colour;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
            r_s1_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s1_valid    <= 1'b1;
                r_line_active <= emit && !is_last;
            end else if (i_ready) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Line state and pixel payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_pix <= n_pix;
            if (emit) begin
                r_cur_x       <= n_cur_x;
                r_cur_y       <= n_cur_y;
                r_target_x    <= tx;
                r_target_y    <= ty;
                r_delta_x     <= dx;
                r_delta_y     <= dy;
                r_step_x_neg  <= sxn;
                r_step_y_neg  <= syn;
                r_error_term  <= n_error_term;
                r_line_colour <= colour;
            end
        end
    end

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && emit && is_last) |=> !r_line_active)
        else $error("line still active after its end point");

    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !emit) |=> (r_s1_valid && !r_s1_pix.valid_res))
        else $error("idle next request produced a pixel");

endmodule

`default_nettype wire

@@ design/blr_addr.sv @@
// Back end address pipeline: clipping, frame buffer address and output register.
`default_nettype none

module blr_addr (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic [blr_pkg::DIM_BITS-1:0]          i_image_width,
    input  wire logic [blr_pkg::DIM_BITS-1:0]          i_image_height,
    input  wire logic                                  i_valid,
    input  blr_pkg::t_pix                              i_pix,
    output logic                                       o_ready,
    input  wire logic                                  i_stall,
    output logic                                       o_valid,
    output logic                                       o_valid_res,
    output logic signed [blr_pkg::COORD_BITS-1:0]      o_pixel_x,
    output logic signed [blr_pkg::COORD_BITS-1:0]      o_pixel_y,
    output logic                                       o_write_enable,
    output logic [blr_pkg::ADDR_BITS-1:0]              o_byte_address,
    output logic [blr_pkg::COLOR_BITS-1:0]             o_out_red,
    output logic [blr_pkg::COLOR_BITS-1:0]             o_out_green,
    output logic [blr_pkg::COLOR_BITS-1:0]             o_out_blue,
    output logic                                       o_last
);
    import blr_pkg::*;

    logic [DIM_BITS-1:0]  w_eff;
    logic [DIM_BITS-1:0]  h_eff;
    logic                 in_image;
    logic                 s2_ready;
    logic                 s3_ready;
    logic [PROD_BITS-1:0] sum;

    // Product stage.
    logic                 r_s2_valid;
    t_pix                 r_s2_pix;
    logic                 r_s2_inside;
    logic [PROD_BITS-1:0] r_s2_prod;

    // Output stage.
    logic                 r_out_valid;
    t_pix                 r_out_pix;
    logic                 r_out_we;
    logic [ADDR_BITS-1:0] r_out_addr;
    logic [ADDR_BITS-1:0] n_out_addr;

    assign s3_ready = !r_out_valid || !i_stall;
    assign s2_ready = !r_s2_valid || s3_ready;
    assign o_ready  = s2_ready;

    // Clip against the saturated image size.
    always_comb begin
        w_eff    = eff_dim(i_image_width);
        h_eff    = eff_dim(i_image_height);
        in_image = i_pix.valid_res && !i_pix.x[COORD_BITS-1] && !i_pix.y[COORD_BITS-1]
                   && (COORD_BITS'(i_pix.x) < COORD_BITS'(w_eff))
                   && (COORD_BITS'(i_pix.y) < COORD_BITS'(h_eff));
    end

    // Row offset plus column, times three bytes per pixel.
    always_comb begin
        sum        = r_s2_prod + PROD_BITS'(r_s2_pix.x[INDEX_BITS-1:0]);
        n_out_addr = r_s2_inside ? ADDR_BITS'({sum, 1'b0}) + ADDR_BITS'(sum) : '0;
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s2_ready) begin
                r_s2_valid <= i_valid;
            end
            if (s3_ready) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (s2_ready && i_valid) begin
            r_s2_pix    <= i_pix;
            r_s2_inside <= in_image;
            r_s2_prod   <= PROD_BITS'(i_pix.y[INDEX_BITS-1:0]) * PROD_BITS'(w_eff);
        end
        if (s3_ready && r_s2_valid) begin
            r_out_pix  <= r_s2_pix;
            r_out_we   <= r_s2_inside;
            r_out_addr <= n_out_addr;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_valid_res    = r_out_pix.valid_res;
    assign o_pixel_x      = r_out_pix.x;
    assign o_pixel_y      = r_out_pix.y;
    assign o_write_enable = r_out_we;
    assign o_byte_address = r_out_addr;
    assign o_out_red      = r_out_pix.colour[3*COLOR_BITS-1:2*COLOR_BITS];
    assign o_out_green    = r_out_pix.colour[2*COLOR_BITS-1:COLOR_BITS];
    assign o_out_blue     = r_out_pix.colour[COLOR_BITS-1:0];
    assign o_last         = r_out_pix.last;

    a_inside_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && s3_ready && r_s2_inside) |=> (o_valid && o_write_enable && o_valid_res))
        else $error("clipped-in pixel lost its write enable");

    a_clipped_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && s3_ready && !r_s2_inside) |=> (o_byte_address == '0))
        else $error("clipped pixel carries an address");

endmodule

`default_nettype wire

@@ design/bresenham_line_rasterizer.sv @@
// Top level of the Bresenham line rasterizer.
// The block takes one request per clock while o_stall is low and returns one pixel
// transaction per request, in order: a start request loads both endpoints and the colour
// and returns the start pixel, each next request returns the following pixel of the
// line, and a next request with no line in progress returns a result with every field
// zero. A result passes the queue, stepper, multiply and output registers; the sustained
// rate is one item per clock while i_stall is low, set by the stepper's position and
// error update. Pixels outside the configured image carry write_enable low and a zero
// address; image sizes above 4096 act as 4096. The user must write configuration
// registers only while no transaction is in flight; the block does not enforce this.
`default_nettype none

module bresenham_line_rasterizer (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // Configuration write port.
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [blr_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  wire logic [blr_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    // Request channel.
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic                                  i_req_type,
    input  wire logic signed [blr_pkg::COORD_BITS-1:0] i_start_x,
    input  wire logic signed [blr_pkg::COORD_BITS-1:0] i_start_y,
    input  wire logic signed [blr_pkg::COORD_BITS-1:0] i_end_x,
    input  wire logic signed [blr_pkg::COORD_BITS-1:0] i_end_y,
    input  wire logic [blr_pkg::COLOR_BITS-1:0]        i_red,
    input  wire logic [blr_pkg::COLOR_BITS-1:0]        i_green,
    input  wire logic [blr_pkg::COLOR_BITS-1:0]        i_blue,
    // Pixel channel.
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic                                       o_valid_res,
    output logic signed [blr_pkg::COORD_BITS-1:0]      o_pixel_x,
    output logic signed [blr_pkg::COORD_BITS-1:0]      o_pixel_y,
    output logic                                       o_write_enable,
    output logic [blr_pkg::ADDR_BITS-1:0]              o_byte_address,
    output logic [blr_pkg::COLOR_BITS-1:0]             o_out_red,
    output logic [blr_pkg::COLOR_BITS-1:0]             o_out_green,
    output logic [blr_pkg::COLOR_BITS-1:0]             o_out_blue,
    output logic                                       o_last
);
    import blr_pkg::*;

    logic [DIM_BITS-1:0] r_image_width;
    logic [DIM_BITS-1:0] r_image_height;

    logic queue_full;
    logic push;
    t_cmd push_cmd;
    logic pop;
    logic head_valid;
    t_cmd head_cmd;
    logic pix_valid;
    t_pix pix;
    logic addr_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_RESET;
            r_image_height <= HEIGHT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
            endcase
        end
    end

    // The request side stalls only on a full queue.
    assign o_stall = queue_full;

    blr_front u_front (
        .i_valid      (i_valid),
        .i_req_type   (i_req_type),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    blr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    blr_stepper u_stepper (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .i_ready     (addr_ready),
        .o_valid     (pix_valid),
        .o_pix       (pix)
    );

    blr_addr u_addr (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_valid        (pix_valid),
        .i_pix          (pix),
        .o_ready        (addr_ready),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_valid_res    (o_valid_res),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_write_enable (o_write_enable),
        .o_byte_address (o_byte_address),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for the Bresenham line rasterizer: scoreboard class, request drivers and pixel checks.

module tb_top;
    import blr_pkg::*;

    // One request transaction as offered on the request channel.
    typedef struct packed {
        t_req_type                    kind;
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
        logic signed [COORD_BITS-1:0] ex;
        logic signed [COORD_BITS-1:0] ey;
        logic [COLOR_BITS-1:0]        r;
        logic [COLOR_BITS-1:0]        g;
        logic [COLOR_BITS-1:0]        b;
    } t_line_req;

    // One pixel transaction as returned on the pixel channel.
    typedef struct packed {
        logic                         valid_res;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         we;
        logic [ADDR_BITS-1:0]         addr;
        logic [COLOR_BITS-1:0]        r;
        logic [COLOR_BITS-1:0]        g;
        logic [COLOR_BITS-1:0]        b;
        logic                         last;
    } t_pixel;

    // Tracks the line being drawn and checks returned pixels in order.
    class t_raster_scoreboard;
        t_pixel              pending_pixels[$];
        int                  errors;
        logic [DIM_BITS-1:0] width_reg;
        logic [DIM_BITS-1:0] height_reg;
        int                  cur_x, cur_y, tgt_x, tgt_y, dx, dy, err;
        bit                  neg_x, neg_y, active;
        logic [23:0]         colour;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            errors     = 0;
            active     = 0;
        endfunction

        function void set_reg(t_cfg_index idx, logic [DIM_BITS-1:0] val);
            if (idx == CFG_IMAGE_WIDTH) begin
                width_reg = val;
            end else begin
                height_reg = val;
            end
        endfunction

        // Sizes above the largest image act as the largest image.
        function int clip_dim(logic [DIM_BITS-1:0] r);
            return (r > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : int'(r);
        endfunction

        // Append an expected pixel at the tail of the queue.
        function void add_expected(t_pixel p);
            pending_pixels = {pending_pixels, p};
        endfunction

        // Produce the current pixel, then take one Bresenham step or close the line.
        function t_pixel emit_pixel();
            t_pixel p;
            int     w, h, e2, e;
            bit     in_image;
            w        = clip_dim(width_reg);
            h        = clip_dim(height_reg);
            in_image = cur_x >= 0 && cur_y >= 0 && cur_x < w && cur_y < h;
            p.valid_res = 1'b1;
            p.x    = COORD_BITS'(cur_x);
            p.y    = COORD_BITS'(cur_y);
            p.we   = in_image;
            p.addr = in_image ? ADDR_BITS'((cur_y * w + cur_x) * 3) : '0;
            p.r    = colour[23:16];
            p.g    = colour[15:8];
            p.b    = colour[7:0];
            p.last = (cur_x == tgt_x) && (cur_y == tgt_y);
            if (p.last) begin
                active = 0;
            end else begin
                e2 = 2 * err;
                e  = err;
                if (e2 > -dy) begin
                    e     -= dy;
                    cur_x += neg_x ? -1 : 1;
                end
                if (e2 < dx) begin
                    e     += dx;
                    cur_y += neg_y ? -1 : 1;
                end
                err = e;
            end
            return p;
        endfunction

        function void note_request(t_line_req q);
            if (q.kind == REQ_START) begin
                cur_x  = q.sx;
                cur_y  = q.sy;
                tgt_x  = q.ex;
                tgt_y  = q.ey;
                dx     = (tgt_x > cur_x) ? tgt_x - cur_x : cur_x - tgt_x;
                dy     = (tgt_y > cur_y) ? tgt_y - cur_y : cur_y - tgt_y;
                neg_x  = !(cur_x < tgt_x);
                neg_y  = !(cur_y < tgt_y);
                err    = dx - dy;
                colour = {q.r, q.g, q.b};
                active = 1;
                add_expected(emit_pixel());
            end else if (!active) begin
                add_expected('0);
            end else begin
                add_expected(emit_pixel());
            end
        endfunction

        function void compare(string name, logic signed [31:0] exp, logic signed [31:0] act);
            if (act !== exp) begin
                $error("%s: expected %0d, got %0d", name, exp, act);
                errors++;
            end
        endfunction

        function void check_pixel(t_pixel act);
            t_pixel e;
            if (pending_pixels.size() == 0) begin
                $error("pixel transaction with no request waiting");
                errors++;
                return;
            end
            e = pending_pixels.pop_front();
            compare("valid_res", e.valid_res, act.valid_res);
            compare("pixel_x", e.x, act.x);
            compare("pixel_y", e.y, act.y);
            compare("write_enable", e.we, act.we);
            compare("byte_address", e.addr, act.addr);
            compare("out_red", e.r, act.r);
            compare("out_green", e.g, act.g);
            compare("out_blue", e.b, act.b);
            compare("last", e.last, act.last);
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]      i_cfg_data = '0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic                          i_req_type = 1'b0;
    logic signed [COORD_BITS-1:0]  i_start_x = '0;
    logic signed [COORD_BITS-1:0]  i_start_y = '0;
    logic signed [COORD_BITS-1:0]  i_end_x = '0;
    logic signed [COORD_BITS-1:0]  i_end_y = '0;
    logic [COLOR_BITS-1:0]         i_red = '0;
    logic [COLOR_BITS-1:0]         i_green = '0;
    logic [COLOR_BITS-1:0]         i_blue = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic                          o_valid_res;
    logic signed [COORD_BITS-1:0]  o_pixel_x;
    logic signed [COORD_BITS-1:0]  o_pixel_y;
    logic                          o_write_enable;
    logic [ADDR_BITS-1:0]          o_byte_address;
    logic [COLOR_BITS-1:0]         o_out_red;
    logic [COLOR_BITS-1:0]         o_out_green;
    logic [COLOR_BITS-1:0]         o_out_blue;
    logic                          o_last;

    t_raster_scoreboard board = new();

    // Idle controls shared by the sender and the receiver.
    int gap_pct   = 20;
    int stall_pct = 20;
    bit hold_off_req = 0;

    bresenham_line_rasterizer i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // A coordinate at or just beyond the image on one axis.
    function automatic int near(int span);
        return int'($urandom_range(0, span + 8)) - 4;
    endfunction

    // Receiver: random stalls, plus one long hold-off when asked for.
    initial begin
        int len;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off_req = 0;
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                i_stall <= 1'b1;
                len = pick_gap();
                repeat (len) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Every accepted pixel transaction goes to the scoreboard.
    always @(posedge i_clk) begin
        t_pixel act;
        if (i_rst_n && o_valid && !i_stall) begin
            act = {o_valid_res, o_pixel_x, o_pixel_y, o_write_enable, o_byte_address,
                   o_out_red, o_out_green, o_out_blue, o_last};
            board.check_pixel(act);
        end
    end

    // Offer one request transaction and hold it until it is accepted.
    task automatic send(t_line_req q);
        int gap;
        i_valid    <= 1'b1;
        i_req_type <= q.kind;
        i_start_x  <= q.sx;
        i_start_y  <= q.sy;
        i_end_x    <= q.ex;
        i_end_y    <= q.ey;
        i_red      <= q.r;
        i_green    <= q.g;
        i_blue     <= q.b;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        board.note_request(q);
        if ($urandom_range(0, 99) < gap_pct) begin
            gap = pick_gap();
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic start_line(int sx, int sy, int ex, int ey,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_line_req q;
        q.kind = REQ_START;
        q.sx   = COORD_BITS'(sx);
        q.sy   = COORD_BITS'(sy);
        q.ex   = COORD_BITS'(ex);
        q.ey   = COORD_BITS'(ey);
        q.r    = r;
        q.g    = g;
        q.b    = b;
        send(q);
    endtask

    // The unused fields of a next request carry random bits.
    task automatic next_pixel();
        t_line_req q;
        q.kind = REQ_NEXT;
        q.sx   = COORD_BITS'($urandom);
        q.sy   = COORD_BITS'($urandom);
        q.ex   = COORD_BITS'($urandom);
        q.ey   = COORD_BITS'($urandom);
        q.r    = COLOR_BITS'($urandom);
        q.g    = COLOR_BITS'($urandom);
        q.b    = COLOR_BITS'($urandom);
        send(q);
    endtask

    // Write both image sizes while the block is idle.
    task automatic write_dims(int w, int h);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_IMAGE_WIDTH;
        i_cfg_data  <= CFG_DATA_BITS'(w);
        @(posedge i_clk);
        board.set_reg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(w));
        i_cfg_index <= CFG_IMAGE_HEIGHT;
        i_cfg_data  <= CFG_DATA_BITS'(h);
        @(posedge i_clk);
        board.set_reg(CFG_IMAGE_HEIGHT, CFG_DATA_BITS'(h));
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (board.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Mostly complete lines near the image, some cut short, some overrun, some stray requests.
    task automatic run_lines(int budget, int w_raw, int h_raw);
        int sent, ws, hs, sx, sy, ex, ey, n, adx, ady, sel, span;
        ws   = (w_raw > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : w_raw;
        hs   = (h_raw > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : h_raw;
        sent = 0;
        while (sent < budget) begin
            sel = $urandom_range(0, 99);
            if (sel < 5) begin
                next_pixel();
                sent++;
            end else begin
                if (sel < 85) begin
                    span = 12;
                end else if (sel < 95) begin
                    span = 60;
                end else begin
                    span = 0;
                end
                if (span > 0) begin
                    sx = near(ws);
                    sy = near(hs);
                    ex = sx + int'($urandom_range(0, 2 * span)) - span;
                    ey = sy + int'($urandom_range(0, 2 * span)) - span;
                end else begin
                    sx = int'($signed(COORD_BITS'($urandom)));
                    sy = int'($signed(COORD_BITS'($urandom)));
                    ex = int'($signed(COORD_BITS'($urandom)));
                    ey = int'($signed(COORD_BITS'($urandom)));
                end
                adx = (ex > sx) ? ex - sx : sx - ex;
                ady = (ey > sy) ? ey - sy : sy - ey;
                n   = (adx > ady) ? adx : ady;
                if (span == 0 && n > 6) begin
                    n = 6;
                end
                sel = $urandom_range(0, 99);
                if (sel < 20) begin
                    n = $urandom_range(0, n);
                end else if (sel < 35) begin
                    n += $urandom_range(1, 2);
                end
                start_line(sx, sy, ex, ey, COLOR_BITS'($urandom), COLOR_BITS'($urandom),
                           COLOR_BITS'($urandom));
                sent++;
                repeat (n) begin
                    next_pixel();
                    sent++;
                end
            end
        end
        i_valid <= 1'b0;
    endtask

    initial begin
        int phase_w[8];
        int phase_h[8];
        phase_w = '{16, 1, 0, 4096, 8191, 4097, 37, 800};
        phase_h = '{16, 1, 5, 4096, 8191, 1, 4096, 600};
        phase_w[7] = $urandom_range(1, 4096);
        phase_h[7] = $urandom_range(1, 4096);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed lines under the reset image size.
        next_pixel();
        start_line(5, 7, 5, 7, 8'hff, 8'h00, 8'hff);
        next_pixel();
        start_line(0, 0, 3, 0, 8'h00, 8'hff, 8'h00);
        repeat (4) next_pixel();
        start_line(10, 5, 10, 2, 8'h12, 8'h34, 8'h56);
        repeat (3) next_pixel();
        start_line(-2, -1, 1, 3, 8'ha5, 8'h5a, 8'hc3);
        repeat (4) next_pixel();
        start_line(-32768, -32768, 32767, 32767, 8'h00, 8'h00, 8'h00);
        repeat (2) next_pixel();
        start_line(32767, 32767, -32768, -32768, 8'hff, 8'hff, 8'hff);
        next_pixel();
        start_line(799, 599, 800, 600, 8'h80, 8'h01, 8'h7f);
        next_pixel();
        i_valid <= 1'b0;
        wait_drained();

        // Random phases, each under its own image size and idle pattern.
        for (int p = 0; p < 8; p++) begin
            write_dims(phase_w[p], phase_h[p]);
            if (p % 3 == 0) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = 25;
                stall_pct = 25;
            end
            if (p == 4) begin
                gap_pct      = 0;
                hold_off_req = 1;
            end
            run_lines(190, phase_w[p], phase_h[p]);
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
